FILE: rtl/mtp_pkg.sv
package mtp_pkg;

  // Storage geometry. The vertex list is split over LANES banks; slot s lives in
  // bank s % LANES at row s / LANES.
  localparam int VERTEX_SLOTS = 256;
  localparam int CORNERS      = 3;
  localparam int LANES        = 8;
  localparam int LANE_W       = $clog2(LANES);
  localparam int ROWS         = (VERTEX_SLOTS + LANES - 1) / LANES;
  localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Field and register widths.
  localparam int VID_W      = 32;
  localparam int LOC_W      = 8;
  localparam int MAXV_W     = 9;
  localparam int MAXP_W     = 11;
  localparam int CNT_W      = ($clog2(VERTEX_SLOTS + 1) > MAXV_W) ?
                              $clog2(VERTEX_SLOTS + 1) : MAXV_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VERTICES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PRIMITIVES = 1'd1;
  localparam logic [MAXV_W-1:0]    MAXV_RESET         = 9'd64;
  localparam logic [MAXP_W-1:0]    MAXP_RESET         = 11'd126;

  typedef logic [VID_W-1:0] vid_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROW_W-1:0] row_t;

  // Write port of one bank.
  typedef struct packed {
    logic en;
    row_t row;
    vid_t data;
  } lane_wr_t;

  // Tag that travels with the registered read data of all banks.
  typedef struct packed {
    logic valid;
    row_t row;
  } rd_tag_t;

  // Search result per corner: whether a stored slot matched, and the highest one.
  typedef struct packed {
    logic [CORNERS-1:0]            hit;
    logic [CORNERS-1:0][CNT_W-1:0] loc;
  } hit_t;

endpackage

FILE: rtl/mtp_lane.sv
module mtp_lane (
  input  logic                          clk,
  input  logic [mtp_pkg::LANE_W-1:0]    lane_id,
  input  mtp_pkg::row_t                 rd_addr,
  input  mtp_pkg::rd_tag_t              rd_tag,
  input  mtp_pkg::lane_wr_t             wr,
  input  mtp_pkg::vid_t [mtp_pkg::CORNERS-1:0] corner,
  input  mtp_pkg::cnt_t                 vertex_count,
  output logic [mtp_pkg::CORNERS-1:0]   match
);
  import mtp_pkg::*;

  vid_t mem [ROWS];
  vid_t rdata;
  cnt_t slot;
  logic slot_live;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    rdata <= mem[rd_addr];
  end

  // Only slots below the current count belong to the open meshlet.
  assign slot      = (cnt_t'(rd_tag.row) << LANE_W) | cnt_t'(lane_id);
  assign slot_live = rd_tag.valid && (slot < vertex_count);

  always_comb begin
    for (int j = 0; j < CORNERS; j++) begin
      match[j] = slot_live && (rdata == corner[j]);
    end
  end

endmodule

FILE: rtl/mtp_merge.sv
module mtp_merge (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            clear,
  input  mtp_pkg::rd_tag_t                                rd_tag,
  input  logic [mtp_pkg::LANES-1:0][mtp_pkg::CORNERS-1:0] match,
  output mtp_pkg::hit_t                                   res
);
  import mtp_pkg::*;

  logic [CORNERS-1:0]             row_hit;
  logic [CORNERS-1:0][LANE_W-1:0] row_lane;

  // Highest matching lane of this row wins, since it is the highest slot.
  always_comb begin
    for (int j = 0; j < CORNERS; j++) begin
      row_hit[j]  = 1'b0;
      row_lane[j] = '0;
      for (int l = 0; l < LANES; l++) begin
        if (match[l][j]) begin
          row_hit[j]  = 1'b1;
          row_lane[j] = LANE_W'(l);
        end
      end
    end
  end

  // Rows arrive in ascending order, so a later hit overrides an earlier one.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res <= '0;
    end else if (rd_tag.valid) begin
      for (int j = 0; j < CORNERS; j++) begin
        if (row_hit[j]) begin
          res.hit[j] <= 1'b1;
          res.loc[j] <= (cnt_t'(rd_tag.row) << LANE_W) | cnt_t'(row_lane[j]);
        end
      end
    end
  end

endmodule

FILE: rtl/meshlet_triangle_packer_core.sv
// Greedy meshlet builder. Each input transaction carries one triangle as three
// global vertex indices plus a flag that closes the open meshlet first. The
// block looks each corner up in the meshlet's list of unique vertices, accepts
// the triangle if both limits leave room and its unmatched corners fit, appends
// those corners in order and returns one output transaction with the local
// indices, the counts after the step and a closed flag (on tlast). The vertex
// list sits in eight banks that are searched side by side, one row of eight
// slots per cycle, over the rows that hold the count in force after the begin
// flag is applied. The search is skipped when the meshlet is empty or a limit
// is already reached. A finished result waits in an output register, so the
// next item may be accepted and searched while the previous one is still held
// there. While that register is still full, the next item waits in its decide
// step. Configuration writes are expected only while the block is idle.
module meshlet_triangle_packer_core (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Triangle input.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [95:0]                     s_tdata,  // vertex_a, vertex_b, vertex_c
  input  logic                            s_tuser,  // begin_new
  // Result output.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [47:0]                     m_tdata,  // local_a, local_b, local_c,
                                                    // added_vertices, vertex_total,
                                                    // primitive_total, zero pad
  output logic                            m_tuser,  // accepted
  output logic                            m_tlast   // meshlet_closed
);
  import mtp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t                         state;
  logic [MAXV_W-1:0]              max_vertices;
  logic [MAXP_W-1:0]              max_primitives;
  cnt_t                           vertex_count;
  logic [MAXP_W-1:0]              primitive_count;
  vid_t [CORNERS-1:0]             corner;
  row_t                           scan_row;
  rd_tag_t                        rd_tag;

  logic                           in_xfer;
  logic                           out_free;
  logic                           commit;
  cnt_t                           limv;
  cnt_t                           vc_start;
  logic [MAXP_W-1:0]              pc_start;
  logic                           start_ok;
  row_t                           last_row;

  hit_t                           hits;
  logic [LANES-1:0][CORNERS-1:0]  match;
  lane_wr_t                       wr [LANES];

  logic                           pre_ok;
  logic [1:0]                     fresh;
  logic [CORNERS-1:0][1:0]        offs;
  cnt_t [CORNERS-1:0]             slot;
  logic                           fits;
  logic                           acc;
  cnt_t                           vc_new;
  logic [MAXP_W-1:0]              pc_new;
  logic                           closed;
  logic [CORNERS-1:0][LOC_W-1:0]  loc;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == ST_DECIDE) && out_free;

  // Effective vertex limit is the smaller of the register and the store size.
  always_comb begin
    if (cnt_t'(max_vertices) < cnt_t'(VERTEX_SLOTS)) begin
      limv = cnt_t'(max_vertices);
    end else begin
      limv = cnt_t'(VERTEX_SLOTS);
    end
  end

  // The begin flag empties the meshlet before the limit check on acceptance.
  assign vc_start = s_tuser ? '0 : vertex_count;
  assign pc_start = s_tuser ? '0 : primitive_count;
  assign start_ok = (vc_start < limv) && (pc_start < max_primitives);
  assign last_row = row_t'((vertex_count - cnt_t'(1)) >> LANE_W);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_vertices   <= MAXV_RESET;
      max_primitives <= MAXP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_VERTICES:   max_vertices   <= cfg_wdata[MAXV_W-1:0];
        REG_MAX_PRIMITIVES: max_primitives <= cfg_wdata[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, scan the banks row by row (skipped when the meshlet is empty
  // or a limit is reached), let the last read retire, then decide and hand the result to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_row <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            scan_row <= '0;
            if (start_ok && (vc_start != '0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_SCAN: begin
          scan_row <= scan_row + row_t'(1);
          if (scan_row == last_row) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The read tag is registered alongside the bank read data, so the two stay aligned.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else begin
      rd_tag.valid <= (state == ST_SCAN);
      rd_tag.row   <= scan_row;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      corner[0] <= s_tdata[31:0];
      corner[1] <= s_tdata[63:32];
      corner[2] <= s_tdata[95:64];
    end
  end

  // Search lanes, one bank each.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mtp_lane u_lane (
      .clk          (clk),
      .lane_id      (LANE_W'(l)),
      .rd_addr      (scan_row),
      .rd_tag       (rd_tag),
      .wr           (wr[l]),
      .corner       (corner),
      .vertex_count (vertex_count),
      .match        (match[l])
    );
  end

  mtp_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .clear  (in_xfer),
    .rd_tag (rd_tag),
    .match  (match),
    .res    (hits)
  );

  // Decision. Unmatched corners each take the next free slot in corner order,
  // so a corner repeated within one triangle gets a slot per copy.
  always_comb begin
    logic [1:0] run;
    run = 2'd0;
    for (int j = 0; j < CORNERS; j++) begin
      offs[j] = run;
      if (!hits.hit[j]) begin
        run = run + 2'd1;
      end
    end
    fresh = run;
  end

  assign pre_ok = (vertex_count < limv) && (primitive_count < max_primitives);
  assign fits   = ({1'b0, vertex_count} + (CNT_W + 1)'(fresh)) <= {1'b0, limv};
  assign acc    = pre_ok && fits;
  assign vc_new = acc ? (vertex_count + cnt_t'(fresh)) : vertex_count;
  assign pc_new = acc ? (primitive_count + MAXP_W'(1)) : primitive_count;
  assign closed = (vc_new >= limv) || (pc_new >= max_primitives);

  always_comb begin
    for (int j = 0; j < CORNERS; j++) begin
      slot[j] = vertex_count + cnt_t'(offs[j]);
      if (!acc) begin
        loc[j] = '0;
      end else if (hits.hit[j]) begin
        loc[j] = hits.loc[j][LOC_W-1:0];
      end else begin
        loc[j] = slot[j][LOC_W-1:0];
      end
    end
  end

  // Appended slots are consecutive, so the three writes land in distinct banks.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr[l] = '0;
      for (int j = 0; j < CORNERS; j++) begin
        if (commit && acc && !hits.hit[j] && (slot[j][LANE_W-1:0] == LANE_W'(l))) begin
          wr[l].en   = 1'b1;
          wr[l].row  = row_t'(slot[j] >> LANE_W);
          wr[l].data = corner[j];
        end
      end
    end
  end

  // Meshlet counts; a closed meshlet starts over empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= '0;
      primitive_count <= '0;
    end else if (in_xfer) begin
      vertex_count    <= vc_start;
      primitive_count <= pc_start;
    end else if (commit) begin
      vertex_count    <= closed ? '0 : vc_new;
      primitive_count <= closed ? '0 : pc_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {2'b00, pc_new, vc_new[MAXV_W-1:0], fresh & {2{acc}},
                  loc[2], loc[1], loc[0]};
      m_tuser <= acc;
      m_tlast <= closed;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mtp_pkg::*;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic              accepted;
    logic [LOC_W-1:0]  local_a;
    logic [LOC_W-1:0]  local_b;
    logic [LOC_W-1:0]  local_c;
    logic [1:0]        added;
    logic [MAXV_W-1:0] vertex_total;
    logic [MAXP_W-1:0] primitive_total;
    logic              closed;
  } tri_result_t;

  // Scoreboard: keeps its own copy of the meshlet being built and of both limit
  // registers, predicts the result of every triangle the block accepts and
  // compares each output transaction against the oldest prediction.
  class meshlet_board;
    logic [MAXV_W-1:0] max_v;
    logic [MAXP_W-1:0] max_p;
    vid_t              slots [VERTEX_SLOTS];
    int unsigned       vcount;
    int unsigned       pcount;
    tri_result_t       expected_q [$];
    int                errors;
    int                n_tris;
    int                n_joined;
    int                n_closes;
    int                n_checked;

    function new();
      max_v    = MAXV_RESET;
      max_p    = MAXP_RESET;
      vcount   = 0;
      pcount   = 0;
      errors   = 0;
      n_tris   = 0;
      n_joined = 0;
      n_closes = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MAX_VERTICES) max_v = val[MAXV_W-1:0];
      else if (idx == REG_MAX_PRIMITIVES) max_p = val[MAXP_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out what one accepted triangle does to the open meshlet.
    function void note_triangle(vid_t a, vid_t b, vid_t c, logic begin_new);
      vid_t        corner [CORNERS];
      int unsigned loc [CORNERS];
      bit          hit [CORNERS];
      int unsigned limv;
      int unsigned fresh;
      tri_result_t r;
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      fresh = 0;
      r = '0;
      for (int j = 0; j < CORNERS; j++) begin
        loc[j] = 0;
        hit[j] = 1'b0;
      end
      if (begin_new) begin
        vcount = 0;
        pcount = 0;
      end
      limv = (max_v < VERTEX_SLOTS) ? max_v : VERTEX_SLOTS;
      if (vcount < limv && pcount < max_p) begin
        // Later slots overwrite earlier ones, so the highest match wins.
        for (int i = 0; i < vcount; i++) begin
          for (int j = 0; j < CORNERS; j++) begin
            if (slots[i] == corner[j]) begin
              loc[j] = i;
              hit[j] = 1'b1;
            end
          end
        end
        for (int j = 0; j < CORNERS; j++) begin
          if (!hit[j]) fresh++;
        end
        if (vcount + fresh <= limv) begin
          // A corner repeated inside the triangle but absent from the list gets
          // a slot for every copy.
          for (int j = 0; j < CORNERS; j++) begin
            if (!hit[j]) begin
              loc[j] = vcount;
              slots[vcount] = corner[j];
              vcount++;
            end
          end
          pcount++;
          r.accepted = 1'b1;
          r.added    = 2'(fresh);
          r.local_a  = LOC_W'(loc[0]);
          r.local_b  = LOC_W'(loc[1]);
          r.local_c  = LOC_W'(loc[2]);
        end
      end
      r.vertex_total    = MAXV_W'(vcount);
      r.primitive_total = MAXP_W'(pcount);
      r.closed = (vcount >= limv) || (pcount >= max_p);
      if (r.closed) begin
        vcount = 0;
        pcount = 0;
      end
      n_tris++;
      if (r.accepted) n_joined++;
      if (r.closed) n_closes++;
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(tri_result_t act);
      tri_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, act);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      n_checked++;
      compare_field("accepted", exp.accepted, act.accepted);
      compare_field("local_a", exp.local_a, act.local_a);
      compare_field("local_b", exp.local_b, act.local_b);
      compare_field("local_c", exp.local_c, act.local_c);
      compare_field("added_vertices", exp.added, act.added);
      compare_field("vertex_total", exp.vertex_total, act.vertex_total);
      compare_field("primitive_total", exp.primitive_total, act.primitive_total);
      compare_field("meshlet_closed", exp.closed, act.closed);
    endfunction
  endclass

  // Every block input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [95:0]           s_tdata = '0;   // vertex_a, vertex_b, vertex_c
  logic                  s_tuser = 1'b0; // begin_new
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;        // local_a, local_b, local_c, added_vertices,
                                         // vertex_total, primitive_total, zero pad
  logic                  m_tuser;        // accepted
  logic                  m_tlast;        // meshlet_closed

  meshlet_board board = new();

  // Stall bookkeeping for the two sides. The sender keeps a run of items with
  // no gaps in send_calm; the receiver keeps its own hold and calm counters, and
  // the main flow asks for a long hold-off through ready_hold_req.
  int   send_calm = 0;
  int   ready_hold = 0;
  int   ready_calm = 0;
  int   ready_hold_req = 0;
  int   ready_pick;
  int   n_settings = 1;

  // Pool of recently used vertex indices, so that triangles share corners the
  // way neighbouring triangles of a real mesh do.
  vid_t recent_ids [$];
  vid_t next_id;

  meshlet_triangle_packer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard limit on the run. It leaves room for every item to take the slowest
  // lookup over a full vertex list plus sender gaps and receiver stalls.
  initial begin
    #16000000;
    $display("tb: failure");
    $finish;
  end

  // Receiver side. A result transaction is taken at every rising edge where
  // m_tvalid and m_tready are both high; m_tready is then chosen for the next
  // cycle. Most stalls are short, a few are long, and now and then a stretch
  // of steady readiness lets the block run at its own pace.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        board.check_result({m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                            m_tdata[25:24], m_tdata[34:26], m_tdata[45:35], m_tlast});
      end
      if (ready_hold_req > 0) begin
        ready_hold = ready_hold_req;
        ready_hold_req = 0;
        ready_calm = 0;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        m_tready <= 1'b0;
      end else if (ready_calm > 0) begin
        ready_calm--;
        m_tready <= 1'b1;
      end else begin
        ready_pick = $urandom_range(0, 99);
        if (ready_pick < 5) begin
          ready_calm = $urandom_range(20, 80);
          m_tready <= 1'b1;
        end else if (ready_pick < 65) begin
          m_tready <= 1'b1;
        end else if (ready_pick < 90) begin
          ready_hold = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end else if (ready_pick < 98) begin
          ready_hold = $urandom_range(3, 10);
          m_tready <= 1'b0;
        end else begin
          ready_hold = $urandom_range(20, 50);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Gap before the next input transaction: mostly none or short, a few long.
  function int pick_gap();
    int pick;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_calm = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one triangle and waits for the block to take it. A valid that stays
  // high across back-to-back transactions is never lowered in between.
  task send_triangle(vid_t a, vid_t b, vid_t c, logic begin_new);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    s_tuser  <= begin_new;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_triangle(a, b, c, begin_new);
  endtask

  // Picks one corner: mostly a vertex the mesh used recently, otherwise the
  // next fresh index of the walk, and sometimes a fully random index.
  function vid_t pick_corner();
    int   pick;
    vid_t id;
    pick = $urandom_range(0, 99);
    if (pick < 55 && recent_ids.size() > 0) begin
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end else if (pick < 88) begin
      id = next_id;
      next_id++;
    end else begin
      id = $urandom();
    end
    recent_ids = {recent_ids, id};
    if (recent_ids.size() > 24) void'(recent_ids.pop_front());
    return id;
  endfunction

  task send_random_triangle(int begin_pct);
    vid_t a;
    vid_t b;
    vid_t c;
    int   dup;
    a = pick_corner();
    b = pick_corner();
    c = pick_corner();
    // Degenerate triangles with a repeated corner now and then.
    dup = $urandom_range(0, 99);
    if (dup < 3) b = a;
    else if (dup < 6) c = b;
    else if (dup < 7) begin
      b = a;
      c = a;
    end
    send_triangle(a, b, c, ($urandom_range(0, 99) < begin_pct));
  endtask

  // Waits until every predicted result has come back, then lets the block's
  // longest lookup time pass before anything else touches it.
  task wait_idle();
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // One configuration phase: both limits are written while the block is idle,
  // then a stream of random triangles follows. The open meshlet is carried over,
  // so a lowered limit may find it already full.
  task run_phase(logic [CFG_DATA_W-1:0] max_v, logic [CFG_DATA_W-1:0] max_p,
                 int n_items, int begin_pct);
    wait_idle();
    write_reg(REG_MAX_VERTICES, max_v);
    write_reg(REG_MAX_PRIMITIVES, max_p);
    cfg_we <= 1'b0;
    n_settings++;
    next_id = $urandom();
    recent_ids.delete();
    for (int n = 0; n < n_items; n++) send_random_triangle(begin_pct);
    s_tvalid <= 1'b0;
  endtask

  initial begin
    next_id = $urandom();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed triangles under the reset limits. A corner repeated three times
    // takes three slots; a later lookup of it must return the highest of them.
    // The extreme indices, a close requested by the flag and a mix of known and
    // new corners follow.
    send_triangle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_triangle(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_triangle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0005, 1'b0);
    send_triangle(32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_triangle(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1);
    send_triangle(32'h5A5A_5A5A, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_triangle(32'h0000_0001, 32'hA5A5_A5A5, 32'h7FFF_FFFF, 1'b0);
    send_triangle(32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0);
    send_triangle(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 1'b1);
    send_triangle(32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
    send_triangle(32'h1234_5678, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    send_triangle(32'h9ABC_DEF0, 32'h1234_5678, 32'h0F0F_0F0F, 1'b0);
    s_tvalid <= 1'b0;

    // Four vertices leave room for one new triangle but not for most next ones,
    // so triangles get turned away without the meshlet closing.
    run_phase(11'd4, 11'd1024, 200, 2);
    // Largest vertex list and primitive limit: long lookups over all banks.
    run_phase(11'd256, 11'd1024, 250, 1);
    // Vertex limit above the slot count, one triangle per meshlet.
    run_phase(11'h1FF, 11'd1, 100, 5);
    // Vertex limit written as zero after masking: nothing ever fits.
    run_phase(11'h200, 11'd126, 20, 10);
    // Zero primitive limit: every triangle is rejected and the meshlet closes.
    run_phase(11'd16, 11'd0, 20, 10);
    // All ones, masked down to the register widths.
    run_phase(11'h7FF, 11'h7FF, 200, 1);
    // Smallest legal vertex limit with a tiny primitive limit.
    run_phase(11'd3, 11'd2, 100, 5);

    // Back to the reset limits, this time with the receiver holding off for a
    // long stretch while the sender offers transactions back to back, so the
    // output register fills and the input stalls.
    wait_idle();
    ready_hold_req = 300;
    send_calm = 400;
    run_phase({2'b00, MAXV_RESET}, MAXP_RESET, 250, 3);

    // Two random settings inside the legal ranges.
    run_phase(CFG_DATA_W'($urandom_range(3, 256)), CFG_DATA_W'($urandom_range(1, 1024)),
              270, 2);
    run_phase(CFG_DATA_W'($urandom_range(3, 256)), CFG_DATA_W'($urandom_range(1, 1024)),
              270, 2);

    wait_idle();
    $display("summary: %0d triangles over %0d limit settings, %0d joined a meshlet,",
             board.n_tris, n_settings, board.n_joined);
    $display("summary: %0d meshlet closes, %0d results checked, %0d mismatches",
             board.n_closes, board.n_checked, board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
